// ===== design/ple_pkg.sv =====
// Shared constants, types and helpers for the positional list engine.
`default_nettype none
package ple_pkg;

	localparam int CAPACITY    = 16;
	localparam int ENTRY_WIDTH = 32;

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

	typedef enum logic [1:0] {
		FUNC_INSERT = 2'd0,
		FUNC_GET    = 2'd1,
		FUNC_REMOVE = 2'd2,
		FUNC_SWAP   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_BADPOS = 2'd1,
		ST_FULL   = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FETCH,
		S_TAKE,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_PUT,
		S_PULL_RD,
		S_PULL_WR,
		S_SWAP_RD,
		S_SWAP_WR_A,
		S_SWAP_WR_B,
		S_DONE
	} state_t;

	typedef struct packed {
		func_t       func;
		logic [4:0]  pos_a;
		logic [3:0]  pos_b;
		logic [31:0] entry_in;
	} req_t;

	typedef struct packed {
		logic [31:0] entry_out;
		status_t     status;
		logic [4:0]  count;
	} rsp_t;

	typedef struct packed {
		logic                   wr_en;
		logic [IDX_W-1:0]       wr_addr;
		logic [ENTRY_WIDTH-1:0] wr_data;
		logic [IDX_W-1:0]       rd_addr;
	} store_req_t;

	// Fit a 32-bit field word to the stored entry width.
	function automatic logic [ENTRY_WIDTH-1:0] to_entry(input logic [31:0] w);
		logic [63:0] wide;
		wide = 64'(w);
		return wide[ENTRY_WIDTH-1:0];
	endfunction

	// Fit a stored entry to the 32-bit result field.
	function automatic logic [31:0] from_entry(input logic [ENTRY_WIDTH-1:0] e);
		logic [63:0] wide;
		wide = 64'(e);
		return wide[31:0];
	endfunction

endpackage
`default_nettype wire

// ===== design/positional_list_engine.sv =====
// Top level of the positional list engine: request sequencer and result register.
//
// Requests arrive on req (valid/stall) and each gives exactly one result on rsp.
// A request is a single list operation: insert, get, remove or swap by position.
// The list lives in a single-port-write, single-port-read store; a small
// sequencer moves one entry at a time (read, then write) through it.
// Steps from acceptance to the result register being loaded:
//   rejected request  straight to the done state
//   get               fetch, take
//   remove            fetch, take, then a read and a write per later entry
//   insert            a read and a write per entry from pos_a up, then put
//   swap              fetch, take, read pos_b, write pos_a, write pos_b
// The request side stalls from acceptance until the result is in the output
// register, so one request is in work at a time; the next can be taken in the
// cycle after that, even while the previous result still waits on rsp.
// If rsp_stall holds a result, a finished request waits in its last state
// until the output register frees up.
// Reset empties the list (count zero) and drops any pending result. Store
// contents are not cleared; only entries written since are ever read.
`default_nettype none
module positional_list_engine (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_stall,
	input  wire ple_pkg::req_t   req,
	output logic                 rsp_valid,
	input  wire logic            rsp_stall,
	output ple_pkg::rsp_t        rsp
);

	ple_pkg::state_t state_q, state_d;

	logic [ple_pkg::CNT_W-1:0]       count_q;
	logic [ple_pkg::CNT_W-1:0]       pa_q, pb_q, ptr_q;
	logic [ple_pkg::CNT_W-1:0]       ptr_m1, ptr_p1;
	ple_pkg::func_t                  func_q;
	ple_pkg::status_t                status_q, status_chk;
	logic [ple_pkg::ENTRY_WIDTH-1:0] word_q, hold_q, rd_data;
	logic                            rsp_valid_q;
	ple_pkg::rsp_t                   rsp_q;
	ple_pkg::store_req_t             st_req;

	logic [ple_pkg::CMP_W-1:0] pa_e, pb_e, cnt_e, cap_e, cnt_out;
	logic accept, out_free, load_out, count_dec;

	assign req_stall = (state_q != ple_pkg::S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign load_out  = (state_q == ple_pkg::S_DONE) && out_free;

	assign pa_e   = ple_pkg::CMP_W'(req.pos_a);
	assign pb_e   = ple_pkg::CMP_W'(req.pos_b);
	assign cnt_e  = ple_pkg::CMP_W'(count_q);
	assign cap_e  = ple_pkg::CMP_W'(ple_pkg::CAPACITY);
	assign ptr_m1 = ptr_q - ple_pkg::CNT_W'(1);
	assign ptr_p1 = ptr_q + ple_pkg::CNT_W'(1);

	// Position checks on the incoming request against the current count.
	always_comb begin
		status_chk = ple_pkg::ST_OK;
		unique case (req.func)
			ple_pkg::FUNC_INSERT: begin
				if (pa_e > cnt_e) begin
					status_chk = ple_pkg::ST_BADPOS;
				end else if (cnt_e == cap_e) begin
					status_chk = ple_pkg::ST_FULL;
				end
			end
			ple_pkg::FUNC_GET, ple_pkg::FUNC_REMOVE: begin
				if (pa_e >= cnt_e) begin
					status_chk = ple_pkg::ST_BADPOS;
				end
			end
			default: begin
				if (pa_e >= cnt_e || pb_e >= cnt_e || pa_e == pb_e) begin
					status_chk = ple_pkg::ST_BADPOS;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ple_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		st_req  = '0;
		unique case (state_q)
			ple_pkg::S_IDLE: begin
				if (accept) begin
					if (status_chk != ple_pkg::ST_OK) begin
						state_d = ple_pkg::S_DONE;
					end else if (req.func == ple_pkg::FUNC_INSERT) begin
						state_d = (cnt_e > pa_e) ? ple_pkg::S_SHIFT_RD : ple_pkg::S_PUT;
					end else begin
						state_d = ple_pkg::S_FETCH;
					end
				end
			end
			ple_pkg::S_FETCH: begin
				st_req.rd_addr = pa_q[ple_pkg::IDX_W-1:0];
				state_d = ple_pkg::S_TAKE;
			end
			ple_pkg::S_TAKE: begin
				if (func_q == ple_pkg::FUNC_REMOVE) begin
					state_d = ((pa_q + ple_pkg::CNT_W'(1)) < count_q) ?
						ple_pkg::S_PULL_RD : ple_pkg::S_DONE;
				end else if (func_q == ple_pkg::FUNC_SWAP) begin
					state_d = ple_pkg::S_SWAP_RD;
				end else begin
					state_d = ple_pkg::S_DONE;
				end
			end
			ple_pkg::S_SHIFT_RD: begin
				st_req.rd_addr = ptr_m1[ple_pkg::IDX_W-1:0];
				state_d = ple_pkg::S_SHIFT_WR;
			end
			ple_pkg::S_SHIFT_WR: begin
				st_req.wr_en   = 1'b1;
				st_req.wr_addr = ptr_q[ple_pkg::IDX_W-1:0];
				st_req.wr_data = rd_data;
				state_d = (ptr_m1 > pa_q) ? ple_pkg::S_SHIFT_RD : ple_pkg::S_PUT;
			end
			ple_pkg::S_PUT: begin
				st_req.wr_en   = 1'b1;
				st_req.wr_addr = pa_q[ple_pkg::IDX_W-1:0];
				st_req.wr_data = word_q;
				state_d = ple_pkg::S_DONE;
			end
			ple_pkg::S_PULL_RD: begin
				st_req.rd_addr = ptr_p1[ple_pkg::IDX_W-1:0];
				state_d = ple_pkg::S_PULL_WR;
			end
			ple_pkg::S_PULL_WR: begin
				st_req.wr_en   = 1'b1;
				st_req.wr_addr = ptr_q[ple_pkg::IDX_W-1:0];
				st_req.wr_data = rd_data;
				state_d = ((ptr_p1 + ple_pkg::CNT_W'(1)) < count_q) ?
					ple_pkg::S_PULL_RD : ple_pkg::S_DONE;
			end
			ple_pkg::S_SWAP_RD: begin
				st_req.rd_addr = pb_q[ple_pkg::IDX_W-1:0];
				state_d = ple_pkg::S_SWAP_WR_A;
			end
			ple_pkg::S_SWAP_WR_A: begin
				st_req.wr_en   = 1'b1;
				st_req.wr_addr = pa_q[ple_pkg::IDX_W-1:0];
				st_req.wr_data = rd_data;
				state_d = ple_pkg::S_SWAP_WR_B;
			end
			ple_pkg::S_SWAP_WR_B: begin
				st_req.wr_en   = 1'b1;
				st_req.wr_addr = pb_q[ple_pkg::IDX_W-1:0];
				st_req.wr_data = hold_q;
				state_d = ple_pkg::S_DONE;
			end
			ple_pkg::S_DONE: begin
				if (out_free) begin
					state_d = ple_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ple_pkg::S_IDLE;
			end
		endcase
	end

	ple_store u_store (
		.clk     (clk),
		.req     (st_req),
		.rd_data (rd_data)
	);

	// Per-request working registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q   <= req.func;
			pa_q     <= pa_e[ple_pkg::CNT_W-1:0];
			pb_q     <= pb_e[ple_pkg::CNT_W-1:0];
			word_q   <= ple_pkg::to_entry(req.entry_in);
			status_q <= status_chk;
			ptr_q    <= count_q;
		end else if (state_q == ple_pkg::S_TAKE) begin
			hold_q <= rd_data;
			ptr_q  <= pa_q;
		end else if (state_q == ple_pkg::S_SHIFT_WR) begin
			ptr_q <= ptr_m1;
		end else if (state_q == ple_pkg::S_PULL_WR) begin
			ptr_q <= ptr_p1;
		end
	end

	// A remove shrinks the list once its last gap-closing move, if any, is done.
	assign count_dec = (state_d == ple_pkg::S_DONE) && (func_q == ple_pkg::FUNC_REMOVE) &&
		((state_q == ple_pkg::S_TAKE) || (state_q == ple_pkg::S_PULL_WR));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (state_q == ple_pkg::S_PUT) begin
			count_q <= count_q + ple_pkg::CNT_W'(1);
		end else if (count_dec) begin
			count_q <= count_q - ple_pkg::CNT_W'(1);
		end
	end

	assign cnt_out = ple_pkg::CMP_W'(count_q);

	always_ff @(posedge clk) begin
		if (load_out) begin
			if (status_q == ple_pkg::ST_OK &&
			    (func_q == ple_pkg::FUNC_GET || func_q == ple_pkg::FUNC_REMOVE)) begin
				rsp_q.entry_out <= ple_pkg::from_entry(hold_q);
			end else begin
				rsp_q.entry_out <= '0;
			end
			rsp_q.status <= status_q;
			rsp_q.count  <= cnt_out[4:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_out) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ple_pkg::CMP_W'(count_q) <= ple_pkg::CMP_W'(ple_pkg::CAPACITY))
		else $error("entry count exceeds capacity");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ple_pkg::S_IDLE || state_q == ple_pkg::S_DONE) |-> !st_req.wr_en)
		else $error("store written outside an operation");

	a_fail_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.status == ple_pkg::ST_OK || rsp.entry_out == '0))
		else $error("failed request returned entry data");

	a_rejected_no_work: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && status_chk != ple_pkg::ST_OK) |=> (state_q == ple_pkg::S_DONE))
		else $error("rejected request entered the sequencer");

endmodule
`default_nettype wire

// ===== design/ple_store.sv =====
// Entry store: one write port and one registered read port.
`default_nettype none
module ple_store (
	input  wire logic                             clk,
	input  wire ple_pkg::store_req_t              req,
	output logic [ple_pkg::ENTRY_WIDTH-1:0]       rd_data
);

	logic [ple_pkg::ENTRY_WIDTH-1:0] mem [ple_pkg::CAPACITY];
	logic [ple_pkg::ENTRY_WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		rd_data_q <= mem[req.rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire
